// File: rtl/olm_pkg.sv
`default_nettype none

package olm_pkg;

    typedef enum logic [5:0] {
        OP_ASSIGN      = 6'd0,  OP_ADD_ASSIGN  = 6'd1,  OP_SUB_ASSIGN  = 6'd2,
        OP_MUL_ASSIGN  = 6'd3,  OP_DIV_ASSIGN  = 6'd4,  OP_MOD_ASSIGN  = 6'd5,
        OP_SHL_ASSIGN  = 6'd6,  OP_SHR_ASSIGN  = 6'd7,  OP_AND_ASSIGN  = 6'd8,
        OP_OR_ASSIGN   = 6'd9,  OP_XOR_ASSIGN  = 6'd10, OP_ADD         = 6'd11,
        OP_SUB         = 6'd12, OP_MUL         = 6'd13, OP_DIV         = 6'd14,
        OP_MOD         = 6'd15, OP_SHL         = 6'd16, OP_SHR         = 6'd17,
        OP_BIT_AND     = 6'd18, OP_BIT_OR      = 6'd19, OP_BIT_XOR     = 6'd20,
        OP_LOG_AND     = 6'd21, OP_LOG_OR      = 6'd22, OP_NOT         = 6'd23,
        OP_BIT_NOT     = 6'd24, OP_DEC         = 6'd25, OP_INC         = 6'd26,
        OP_EQ          = 6'd27, OP_NE          = 6'd28, OP_LT          = 6'd29,
        OP_LE          = 6'd30, OP_GT          = 6'd31, OP_GE          = 6'd32,
        OP_QUESTION    = 6'd33, OP_COLON       = 6'd34, OP_SEMICOLON   = 6'd35,
        OP_COMMA       = 6'd36, OP_LPAREN      = 6'd37, OP_RPAREN      = 6'd38,
        OP_LBRACKET    = 6'd39, OP_RBRACKET    = 6'd40, OP_NONE        = 6'd41
    } op_code_t;

    localparam logic [7:0] CHAR_LOW  = 8'd32;
    localparam logic [8:0] CHAR_HIGH = 9'd128;
    localparam logic [1:0] MAX_LEN   = 2'd3;

    function automatic op_code_t lookup1(logic [7:0] a);
        op_code_t code;
        unique case (a)
            "=":     code = OP_ASSIGN;
            "+":     code = OP_ADD;
            "-":     code = OP_SUB;
            "*":     code = OP_MUL;
            "/":     code = OP_DIV;
            "%":     code = OP_MOD;
            "&":     code = OP_BIT_AND;
            "|":     code = OP_BIT_OR;
            "^":     code = OP_BIT_XOR;
            "!":     code = OP_NOT;
            "~":     code = OP_BIT_NOT;
            "<":     code = OP_LT;
            ">":     code = OP_GT;
            "?":     code = OP_QUESTION;
            ":":     code = OP_COLON;
            ";":     code = OP_SEMICOLON;
            ",":     code = OP_COMMA;
            "(":     code = OP_LPAREN;
            ")":     code = OP_RPAREN;
            "[":     code = OP_LBRACKET;
            "]":     code = OP_RBRACKET;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic op_code_t lookup2(logic [7:0] a, logic [7:0] b);
        op_code_t code;
        unique case ({a, b})
            "+=":    code = OP_ADD_ASSIGN;
            "-=":    code = OP_SUB_ASSIGN;
            "*=":    code = OP_MUL_ASSIGN;
            "/=":    code = OP_DIV_ASSIGN;
            "%=":    code = OP_MOD_ASSIGN;
            "&=":    code = OP_AND_ASSIGN;
            "|=":    code = OP_OR_ASSIGN;
            "^=":    code = OP_XOR_ASSIGN;
            "<<":    code = OP_SHL;
            ">>":    code = OP_SHR;
            "&&":    code = OP_LOG_AND;
            "||":    code = OP_LOG_OR;
            "--":    code = OP_DEC;
            "++":    code = OP_INC;
            "==":    code = OP_EQ;
            "!=":    code = OP_NE;
            "<=":    code = OP_LE;
            ">=":    code = OP_GE;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

    function automatic op_code_t lookup3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        op_code_t code;
        unique case ({a, b, c})
            "<<=":   code = OP_SHL_ASSIGN;
            ">>=":   code = OP_SHR_ASSIGN;
            default: code = OP_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/operator_longest_match.sv
// A last beat is held in the input register, then its result in the result register.
// Throughput: one character beat per cycle, set by the single prefix-update stage
// that reads and writes the match state in the same cycle; a last beat stalls while
// the result register is full and not taken. The result register lets a new beat
// enter while a result waits to be taken. Reset: rst_n asynchronous active low;
// clears valids and the match state (empty prefix, no operator).
`default_nettype none

module operator_longest_match (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic [7:0] character,
    input  wire logic       last,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [5:0]      operator_code,
    output logic [1:0]      match_length
);
    import olm_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s2_take;

    logic [7:0] prefix_chars_reg [2];
    logic [7:0] prefix_chars_next [2];
    logic [1:0] prefix_count_reg, prefix_count_next;
    op_code_t   best_code_reg, best_code_next;
    logic [1:0] best_length_reg, best_length_next;
    logic       match_done_reg, match_done_next;

    op_code_t   upd_code;
    logic [1:0] upd_length;
    op_code_t   found;
    logic       out_of_range;

    logic       result_valid_reg, result_valid_next;
    logic [5:0] operator_code_reg;
    logic [1:0] match_length_reg;

    assign s2_take    = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign char_ready = !s1_valid_reg || s2_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            s1_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            s1_char_reg <= character;
            s1_last_reg <= last;
        end
    end

    assign out_of_range = (s1_char_reg < CHAR_LOW) || ({1'b0, s1_char_reg} >= CHAR_HIGH);

    always_comb
    begin
        unique case (prefix_count_reg)
            2'd0:    found = lookup1(s1_char_reg);
            2'd1:    found = lookup2(prefix_chars_reg[0], s1_char_reg);
            2'd2:    found = lookup3(prefix_chars_reg[0], prefix_chars_reg[1], s1_char_reg);
            default: found = OP_NONE;
        endcase
    end

    always_comb
    begin
        prefix_chars_next = prefix_chars_reg;
        prefix_count_next = prefix_count_reg;
        best_code_next    = best_code_reg;
        best_length_next  = best_length_reg;
        match_done_next   = match_done_reg;
        upd_code          = best_code_reg;
        upd_length        = best_length_reg;
        if (s2_take)
        begin
            if (!match_done_reg)
            begin
                if (out_of_range || prefix_count_reg == MAX_LEN || found == OP_NONE)
                begin
                    match_done_next = 1'b1;
                end
                else
                begin
                    upd_code   = found;
                    upd_length = 2'(prefix_count_reg + 2'd1);
                    if (prefix_count_reg != 2'd2)
                    begin
                        prefix_chars_next[prefix_count_reg[0]] = s1_char_reg;
                    end
                    prefix_count_next = upd_length;
                    best_code_next    = upd_code;
                    best_length_next  = upd_length;
                end
            end
            if (s1_last_reg)
            begin
                prefix_chars_next[0] = 8'd0;
                prefix_chars_next[1] = 8'd0;
                prefix_count_next    = 2'd0;
                best_code_next       = OP_NONE;
                best_length_next     = 2'd0;
                match_done_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg[0] <= 8'd0;
            prefix_chars_reg[1] <= 8'd0;
            prefix_count_reg    <= 2'd0;
            best_code_reg       <= OP_NONE;
            best_length_reg     <= 2'd0;
            match_done_reg      <= 1'b0;
        end
        else
        begin
            prefix_chars_reg <= prefix_chars_next;
            prefix_count_reg <= prefix_count_next;
            best_code_reg    <= best_code_next;
            best_length_reg  <= best_length_next;
            match_done_reg   <= match_done_next;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        if (s2_take && s1_last_reg)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_last_reg)
        begin
            operator_code_reg <= upd_code;
            match_length_reg  <= upd_length;
        end
    end

    assign result_valid  = result_valid_reg;
    assign operator_code = operator_code_reg;
    assign match_length  = match_length_reg;

`ifndef NO_ASSERTIONS
    a_len_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((match_length == 2'd0) == (operator_code == OP_NONE)))
        else $error("match length disagrees with operator code");

    a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (operator_code <= OP_NONE))
        else $error("operator code out of range");

    a_best_tracks_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        best_length_reg == prefix_count_reg)
        else $error("best length differs from prefix count");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_take && s1_last_reg) |=>
            (prefix_count_reg == 2'd0 && !match_done_reg && best_code_reg == OP_NONE))
        else $error("match state not cleared after last beat");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && result_valid_reg && !result_ready) |-> !s2_take)
        else $error("last beat taken while result register is full");
`endif

endmodule

`default_nettype wire

// File: test/operator_longest_match_tb.sv
`default_nettype none

module operator_longest_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int HOLD_CYCLES    = 200;

    typedef struct {
        op_code_t   code;
        logic [1:0] length;
    } lookup_result_t;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    logic [7:0] character;
    logic       last;
    logic       result_valid;
    logic       result_ready;
    logic [5:0] operator_code;
    logic [1:0] match_length;

    logic [7:0]  held_chars [2];
    int unsigned held_count;
    op_code_t    best_op;
    logic [1:0]  best_len;
    bit          search_over;

    lookup_result_t pending_results [$];
    int             error_count;
    int             beats_sent;
    bit             idle_enable;
    int             hold_cycles_left;
    int             stall_left;
    int             quiet_cycles;

    operator_longest_match u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .character     (character),
        .last          (last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .operator_code (operator_code),
        .match_length  (match_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic string op_text(op_code_t op);
        string t;
        case (op)
            OP_ASSIGN:     t = "=";
            OP_ADD_ASSIGN: t = "+=";
            OP_SUB_ASSIGN: t = "-=";
            OP_MUL_ASSIGN: t = "*=";
            OP_DIV_ASSIGN: t = "/=";
            OP_MOD_ASSIGN: t = "%=";
            OP_SHL_ASSIGN: t = "<<=";
            OP_SHR_ASSIGN: t = ">>=";
            OP_AND_ASSIGN: t = "&=";
            OP_OR_ASSIGN:  t = "|=";
            OP_XOR_ASSIGN: t = "^=";
            OP_ADD:        t = "+";
            OP_SUB:        t = "-";
            OP_MUL:        t = "*";
            OP_DIV:        t = "/";
            OP_MOD:        t = "%";
            OP_SHL:        t = "<<";
            OP_SHR:        t = ">>";
            OP_BIT_AND:    t = "&";
            OP_BIT_OR:     t = "|";
            OP_BIT_XOR:    t = "^";
            OP_LOG_AND:    t = "&&";
            OP_LOG_OR:     t = "||";
            OP_NOT:        t = "!";
            OP_BIT_NOT:    t = "~";
            OP_DEC:        t = "--";
            OP_INC:        t = "++";
            OP_EQ:         t = "==";
            OP_NE:         t = "!=";
            OP_LT:         t = "<";
            OP_LE:         t = "<=";
            OP_GT:         t = ">";
            OP_GE:         t = ">=";
            OP_QUESTION:   t = "?";
            OP_COLON:      t = ":";
            OP_SEMICOLON:  t = ";";
            OP_COMMA:      t = ",";
            OP_LPAREN:     t = "(";
            OP_RPAREN:     t = ")";
            OP_LBRACKET:   t = "[";
            OP_RBRACKET:   t = "]";
            default:       t = "";
        endcase
        return t;
    endfunction

    function automatic void clear_munch();
        held_chars[0] = 8'd0;
        held_chars[1] = 8'd0;
        held_count    = 0;
        best_op       = OP_NONE;
        best_len      = 2'd0;
        search_over   = 1'b0;
    endfunction

    function automatic void munch_byte(logic [7:0] c);
        logic [7:0]  cand [3];
        int unsigned n;
        bit          is_prefix;
        bit          same;
        string       t;
        if (search_over)
            return;
        if (c < CHAR_LOW || c >= CHAR_HIGH || held_count >= MAX_LEN)
        begin
            search_over = 1'b1;
            return;
        end
        cand[0] = held_chars[0];
        cand[1] = held_chars[1];
        cand[2] = 8'd0;
        cand[held_count] = c;
        n = held_count + 1;
        is_prefix = 1'b0;
        for (int k = 0; k < int'(OP_NONE); k++)
        begin
            t = op_text(op_code_t'(k));
            if (t.len() >= n)
            begin
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (8'(t[i]) != cand[i])
                        same = 1'b0;
                if (same)
                begin
                    is_prefix = 1'b1;
                    if (t.len() == n)
                    begin
                        best_op  = op_code_t'(k);
                        best_len = 2'(n);
                    end
                end
            end
        end
        if (!is_prefix)
            search_over = 1'b1;
        else
        begin
            if (n <= 2)
                held_chars[n - 1] = c;
            held_count = n;
        end
    endfunction

    task automatic send_char(logic [7:0] c, bit fin);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        character  <= c;
        last       <= fin;
        do @(posedge clk); while (!char_ready);
        munch_byte(c);
        beats_sent++;
        if (fin)
        begin
            pending_results.push_back('{best_op, best_len});
            clear_munch();
        end
    endtask

    task automatic send_text(logic [7:0] text [$]);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_string(string s);
        logic [7:0] text [$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(8'(s[i]));
        send_text(text);
    endtask

    function automatic logic [7:0] random_tail_char();
        string t;
        int    pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            t = op_text(op_code_t'($urandom_range(0, int'(OP_NONE) - 1)));
            return 8'(t[$urandom_range(0, t.len() - 1)]);
        end
        else if (pick < 8)
            return 8'($urandom_range(32, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_lookup();
        logic [7:0] text [$];
        string      t;
        int         extra;
        if ($urandom_range(0, 99) < 15)
        begin
            extra = $urandom_range(1, 5);
            repeat (extra) text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            t = op_text(op_code_t'($urandom_range(0, int'(OP_NONE) - 1)));
            for (int i = 0; i < t.len(); i++)
                text.push_back(8'(t[i]));
            extra = $urandom_range(0, 2);
            repeat (extra) text.push_back(random_tail_char());
        end
        send_text(text);
    endtask

    task automatic test_field_extremes();
        send_char(8'd0, 1'b1);
        send_char(8'd255, 1'b1);
        send_char(8'd32, 1'b1);
        send_char("a", 1'b1);
        send_char("-", 1'b0);
        send_char(8'd127, 1'b1);
    endtask

    task automatic test_munch_cases();
        send_string("&&");
        send_string("<<=");
        send_string(">>==");
        send_string("!=");
        send_string("|||");
        send_char("+", 1'b0);
        send_char(8'd200, 1'b0);
        send_char("=", 1'b1);
        send_char("<", 1'b0);
        send_char("<", 1'b0);
        send_char("x", 1'b1);
    endtask

    task automatic test_receiver_hold();
        idle_enable = 1'b0;
        hold_cycles_left = HOLD_CYCLES;
        repeat (15) send_random_lookup();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_lookups();
        while (beats_sent < 1250)
            send_random_lookup();
    endtask

    task automatic test_steady_stream();
        idle_enable = 1'b0;
        while (beats_sent < 1650)
            send_random_lookup();
    endtask

    initial
    begin
        lookup_result_t exp_result;
        result_ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result code=%0d length=%0d",
                             $time, operator_code, match_length);
                    error_count++;
                end
                else
                begin
                    exp_result = pending_results.pop_front();
                    if (operator_code !== 6'(exp_result.code))
                    begin
                        $display("%0t: operator_code expected %0d actual %0d",
                                 $time, exp_result.code, operator_code);
                        error_count++;
                    end
                    if (match_length !== exp_result.length)
                    begin
                        $display("%0t: match_length expected %0d actual %0d",
                                 $time, exp_result.length, match_length);
                        error_count++;
                    end
                end
            end
            if (hold_cycles_left > 0)
            begin
                hold_cycles_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((char_valid && char_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        char_valid  = 1'b0;
        character   = 8'd0;
        last        = 1'b0;
        error_count = 0;
        beats_sent  = 0;
        idle_enable = 1'b1;
        hold_cycles_left = 0;
        clear_munch();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_munch_cases();
        test_receiver_hold();
        test_random_lookups();
        test_steady_stream();

        char_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/olm_pkg.sv
rtl/operator_longest_match.sv
test/operator_longest_match_tb.sv
